>>> src/rdtl_pkg.sv
package rdtl_pkg;

  localparam int NUM_STATES = 256;
  localparam int MAX_RUNS   = 32;

  typedef enum logic [1:0] {
    OP_RUN_WR = 2'd0,
    OP_CNT_WR = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COUNT,
    S_WALK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] state_id;
    logic [4:0] slot;
    logic [7:0] run_len_minus_one;
    logic [7:0] run_target;
    logic [5:0] run_count;
    logic [7:0] symbol;
  } in_t;

  typedef struct packed {
    logic [7:0] next_state;
    logic       found;
  } out_t;

endpackage

>>> src/rdtl_run_mem.sv
module rdtl_run_mem #(
  parameter int ADDR_W = 13,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/rdtl_count_mem.sv
module rdtl_count_mem #(
  parameter int NUM_STATES = rdtl_pkg::NUM_STATES,
  parameter int ST_W       = 8,
  parameter int CNT_W      = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [ST_W-1:0]  wr_addr,
  input  logic [CNT_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [ST_W-1:0]  rd_addr,
  output logic [CNT_W-1:0] rd_data,
  output logic             clearing
);

  logic [CNT_W-1:0] mem [NUM_STATES];
  logic [ST_W-1:0]  clr_idx;

  // zero sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == ST_W'(NUM_STATES - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/rle_dfa_transition_lookup_unit.sv
// lookup: result registered after the count read and the run walk (both skipped for a
//   state at or above NUM_STATES), reading one run entry per cycle from the run memory
// writes: done in S_IDLE; a new request is taken again once the result is handed off
// reset: run counts are zeroed by a sweep over every state with in_ready low;
//   run memory is not initialized
module rle_dfa_transition_lookup_unit #(
  parameter int NUM_STATES = rdtl_pkg::NUM_STATES,
  parameter int MAX_RUNS   = rdtl_pkg::MAX_RUNS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rdtl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rdtl_pkg::out_t out_data
);

  localparam int ST_W  = $clog2(NUM_STATES);
  localparam int RUN_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int CNT_W = $clog2(MAX_RUNS + 1);
  localparam int ACC_W = $clog2(MAX_RUNS * 256 + 1);
  localparam int ADR_W = ST_W + RUN_W;

  rdtl_pkg::state_t state, state_next;

  logic [ST_W-1:0]  st, st_next;
  logic [7:0]       sym, sym_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [ACC_W-1:0] acc, acc_next;
  rdtl_pkg::out_t   res, res_next;

  logic             in_acc;
  logic             st_ok;
  logic             slot_ok;
  logic [CNT_W-1:0] cnt_sat;
  logic             load_out;

  logic             run_wr_en;
  logic [ADR_W-1:0] run_wr_addr;
  logic [15:0]      run_wr_data;
  logic             run_rd_en;
  logic [ADR_W-1:0] run_rd_addr;
  logic [15:0]      run_rd_data;

  logic             cnt_wr_en;
  logic             cnt_rd_en;
  logic [CNT_W-1:0] cnt_rd_data;
  logic             clearing;

  logic [ACC_W-1:0] end_pos;
  logic             hit;
  logic [CNT_W-1:0] idx_inc;
  logic             last;

  rdtl_run_mem #(
    .ADDR_W(ADR_W),
    .DATA_W(16)
  ) u_run_mem (
    .clk     (clk),
    .wr_en   (run_wr_en),
    .wr_addr (run_wr_addr),
    .wr_data (run_wr_data),
    .rd_en   (run_rd_en),
    .rd_addr (run_rd_addr),
    .rd_data (run_rd_data)
  );

  rdtl_count_mem #(
    .NUM_STATES(NUM_STATES),
    .ST_W      (ST_W),
    .CNT_W     (CNT_W)
  ) u_count_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cnt_wr_en),
    .wr_addr  (ST_W'(in_data.state_id)),
    .wr_data  (cnt_sat),
    .rd_en    (cnt_rd_en),
    .rd_addr  (ST_W'(in_data.state_id)),
    .rd_data  (cnt_rd_data),
    .clearing (clearing)
  );

  assign in_ready = (state == rdtl_pkg::S_IDLE) && !clearing;
  assign in_acc   = in_valid && in_ready;
  assign st_ok    = 32'(in_data.state_id) < NUM_STATES;
  assign slot_ok  = 32'(in_data.slot) < MAX_RUNS;
  assign cnt_sat  = (32'(in_data.run_count) > MAX_RUNS) ? CNT_W'(MAX_RUNS)
                                                        : CNT_W'(in_data.run_count);

  assign run_wr_en   = in_acc && (in_data.opcode == rdtl_pkg::OP_RUN_WR) && st_ok && slot_ok;
  assign run_wr_addr = {ST_W'(in_data.state_id), RUN_W'(in_data.slot)};
  assign run_wr_data = {in_data.run_target, in_data.run_len_minus_one};
  assign cnt_wr_en   = in_acc && (in_data.opcode == rdtl_pkg::OP_CNT_WR) && st_ok;

  // shared add and compare over the run list
  assign end_pos  = acc + ACC_W'(run_rd_data[7:0]);
  assign hit      = ACC_W'(sym) <= end_pos;
  assign idx_inc  = idx + 1'b1;
  assign last     = idx_inc == cnt;
  assign load_out = (state == rdtl_pkg::S_RESP) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      rdtl_pkg::S_IDLE: begin
        if (in_acc && (in_data.opcode == rdtl_pkg::OP_LOOKUP)) begin
          state_next = st_ok ? rdtl_pkg::S_COUNT : rdtl_pkg::S_RESP;
        end
      end
      rdtl_pkg::S_COUNT: begin
        state_next = (cnt_rd_data == '0) ? rdtl_pkg::S_RESP : rdtl_pkg::S_WALK;
      end
      rdtl_pkg::S_WALK: begin
        if (hit || last) begin
          state_next = rdtl_pkg::S_RESP;
        end
      end
      rdtl_pkg::S_RESP: begin
        if (!out_valid || out_ready) begin
          state_next = rdtl_pkg::S_IDLE;
        end
      end
      default: state_next = rdtl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    st_next     = st;
    sym_next    = sym;
    cnt_next    = cnt;
    idx_next    = idx;
    acc_next    = acc;
    res_next    = res;
    cnt_rd_en   = 1'b0;
    run_rd_en   = 1'b0;
    run_rd_addr = {st, RUN_W'(0)};
    case (state)
      rdtl_pkg::S_IDLE: begin
        if (in_acc && (in_data.opcode == rdtl_pkg::OP_LOOKUP)) begin
          st_next   = ST_W'(in_data.state_id);
          sym_next  = in_data.symbol;
          res_next  = '0;
          cnt_rd_en = st_ok;
        end
      end
      rdtl_pkg::S_COUNT: begin
        cnt_next  = cnt_rd_data;
        idx_next  = '0;
        acc_next  = '0;
        run_rd_en = 1'b1;
      end
      rdtl_pkg::S_WALK: begin
        if (hit) begin
          res_next.next_state = run_rd_data[15:8];
          res_next.found      = 1'b1;
        end else begin
          acc_next    = end_pos + 1'b1;
          idx_next    = idx_inc;
          run_rd_en   = !last;
          run_rd_addr = {st, idx_inc[RUN_W-1:0]};
        end
      end
      rdtl_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rdtl_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    st  <= st_next;
    sym <= sym_next;
    cnt <= cnt_next;
    idx <= idx_next;
    acc <= acc_next;
    res <= res_next;
    if (load_out) begin
      out_data <= res;
    end
  end

  a_walk_in_count: assert property (@(posedge clk) disable iff (rst)
    (state == rdtl_pkg::S_WALK) |-> (idx < cnt))
    else $error("run walk past the state's run count");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    (state == rdtl_pkg::S_WALK) |-> (acc <= (ACC_W'(idx) << 8)))
    else $error("run start exceeds the runs walked");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.found || (out_data.next_state == '0)))
    else $error("miss with nonzero next state");

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (in_data.opcode == rdtl_pkg::OP_LOOKUP)) |=> !in_ready)
    else $error("request taken during a lookup");

  a_no_req_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("request taken during count clear");

endmodule

>>> tb/rle_dfa_transition_lookup_unit_test.sv
module rle_dfa_transition_lookup_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = rdtl_pkg::MAX_RUNS + 8;
  localparam int PHASE_ITEMS = 280;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rdtl_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rdtl_pkg::out_t out_data;

  rle_dfa_transition_lookup_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // table as seen by the predictor, updated on acceptance
  logic [7:0] run_target_of [rdtl_pkg::NUM_STATES][rdtl_pkg::MAX_RUNS];
  logic [7:0] run_len_of [rdtl_pkg::NUM_STATES][rdtl_pkg::MAX_RUNS];
  logic [5:0] runs_in_state [rdtl_pkg::NUM_STATES];

  // table as planned by the stimulus, used to keep lookups off unwritten entries
  logic [7:0] plan_len [rdtl_pkg::NUM_STATES][rdtl_pkg::MAX_RUNS];
  logic [rdtl_pkg::MAX_RUNS-1:0] plan_written [rdtl_pkg::NUM_STATES];
  int plan_runs [rdtl_pkg::NUM_STATES];

  rdtl_pkg::in_t pending_requests [$];
  rdtl_pkg::out_t expected_moves [$];

  logic [7:0] hot_state = '0;
  bit gap_on = 1'b1;
  bit stall_on = 1'b1;
  int send_wait = 0;
  int recv_wait = 0;
  int planned_items = 0;
  int accepted_requests = 0;
  int run_writes = 0;
  int count_writes = 0;
  int saturating_counts = 0;
  int lookups_checked = 0;
  int hits = 0;
  int gap_hits = 0;
  int misses = 0;
  int mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic rdtl_pkg::out_t predict_move(logic [7:0] st, logic [7:0] sym);
    rdtl_pkg::out_t mv;
    int run_end;
    mv = '0;
    run_end = -1;
    for (int i = 0; i < int'(runs_in_state[st]); i++) begin
      run_end += int'(run_len_of[st][i]) + 1;
      if (int'(sym) <= run_end) begin
        mv.next_state = run_target_of[st][i];
        mv.found = 1'b1;
        return mv;
      end
    end
    return mv;
  endfunction

  function automatic void enqueue_request(rdtl_pkg::in_t rq);
    pending_requests = {pending_requests, rq};
  endfunction

  function automatic void absorb_request(rdtl_pkg::in_t rq);
    case (rq.opcode)
      rdtl_pkg::OP_RUN_WR: begin
        run_target_of[rq.state_id][rq.slot] = rq.run_target;
        run_len_of[rq.state_id][rq.slot] = rq.run_len_minus_one;
        run_writes++;
      end
      rdtl_pkg::OP_CNT_WR: begin
        if (rq.run_count > rdtl_pkg::MAX_RUNS) begin
          runs_in_state[rq.state_id] = 6'(rdtl_pkg::MAX_RUNS);
          saturating_counts++;
        end else begin
          runs_in_state[rq.state_id] = rq.run_count;
        end
        count_writes++;
      end
      rdtl_pkg::OP_LOOKUP: begin
        expected_moves = {expected_moves, predict_move(rq.state_id, rq.symbol)};
      end
      default: ;
    endcase
  endfunction

  function automatic void check_move(rdtl_pkg::out_t got);
    rdtl_pkg::out_t want;
    if (expected_moves.size() == 0) begin
      $error("result with no lookup outstanding: next_state %0d found %0d",
             got.next_state, got.found);
      mismatches++;
      return;
    end
    want = expected_moves.pop_front();
    lookups_checked++;
    if (got.next_state !== want.next_state) begin
      $error("next_state: expected %0d, got %0d", want.next_state, got.next_state);
      mismatches++;
    end
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      mismatches++;
    end
    if (!want.found) begin
      misses++;
    end else if (want.next_state == '0) begin
      gap_hits++;
    end else begin
      hits++;
    end
  endfunction

  function automatic int pick_idle(bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] random_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 8'($urandom_range(0, 15));
    if (r < 8) return 8'($urandom_range(0, 63));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] random_symbol();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r < 6) return 8'($urandom_range(0, 40));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] random_state();
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
    return hot_state;
  endfunction

  function automatic rdtl_pkg::in_t random_request(logic [1:0] op, logic [7:0] st);
    logic [63:0] bits;
    rdtl_pkg::in_t rq;
    bits = {$urandom, $urandom};
    rq = bits[$bits(rdtl_pkg::in_t)-1:0];
    rq.opcode = op;
    rq.state_id = st;
    return rq;
  endfunction

  function automatic void plan_run(logic [7:0] st, logic [4:0] slot, logic [7:0] len,
                                   logic [7:0] tgt);
    rdtl_pkg::in_t rq;
    rq = random_request(rdtl_pkg::OP_RUN_WR, st);
    rq.slot = slot;
    rq.run_len_minus_one = len;
    rq.run_target = tgt;
    plan_len[st][slot] = len;
    plan_written[st][slot] = 1'b1;
    enqueue_request(rq);
    planned_items++;
  endfunction

  function automatic void plan_count(logic [7:0] st, logic [5:0] cnt);
    rdtl_pkg::in_t rq;
    rq = random_request(rdtl_pkg::OP_CNT_WR, st);
    rq.run_count = cnt;
    plan_runs[st] = (cnt > rdtl_pkg::MAX_RUNS) ? rdtl_pkg::MAX_RUNS : int'(cnt);
    enqueue_request(rq);
    planned_items++;
  endfunction

  function automatic int first_unwritten_read(logic [7:0] st, logic [7:0] sym);
    int run_end;
    run_end = -1;
    for (int i = 0; i < plan_runs[st]; i++) begin
      if (!plan_written[st][i]) return i;
      run_end += int'(plan_len[st][i]) + 1;
      if (int'(sym) <= run_end) return -1;
    end
    return -1;
  endfunction

  function automatic void plan_lookup(logic [7:0] st, logic [7:0] sym);
    rdtl_pkg::in_t rq;
    int hole;
    // fill any run entry the walk would reach before it is written
    hole = first_unwritten_read(st, sym);
    while (hole >= 0) begin
      plan_run(st, 5'(hole), random_len(), 8'($urandom_range(0, 255)));
      hole = first_unwritten_read(st, sym);
    end
    rq = random_request(rdtl_pkg::OP_LOOKUP, st);
    rq.symbol = sym;
    enqueue_request(rq);
    planned_items++;
  endfunction

  function automatic void plan_noise();
    enqueue_request(random_request(OP_UNUSED, 8'($urandom_range(0, 255))));
  endfunction

  function automatic void plan_table();
    logic [7:0] st;
    int runs;
    int lookups;
    st = 8'($urandom_range(0, 255));
    runs = ($urandom_range(0, 7) == 0) ? $urandom_range(1, rdtl_pkg::MAX_RUNS)
                                       : $urandom_range(1, 6);
    for (int i = 0; i < runs; i++) begin
      plan_run(st, 5'(i), random_len(), 8'($urandom_range(0, 255)));
    end
    if (runs == rdtl_pkg::MAX_RUNS && $urandom_range(0, 1) == 1) begin
      plan_count(st, 6'($urandom_range(rdtl_pkg::MAX_RUNS, 63)));
    end else begin
      plan_count(st, 6'(runs));
    end
    lookups = $urandom_range(2, 8);
    for (int i = 0; i < lookups; i++) begin
      plan_lookup(st, random_symbol());
    end
    hot_state = st;
  endfunction

  function automatic void plan_random_step();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      plan_table();
    end else if (pick < 70) begin
      plan_lookup(random_state(), random_symbol());
    end else if (pick < 82) begin
      plan_run(random_state(), 5'($urandom_range(0, rdtl_pkg::MAX_RUNS - 1)), random_len(),
               8'($urandom_range(0, 255)));
    end else if (pick < 92) begin
      plan_count(random_state(), 6'($urandom_range(0, 63)));
    end else begin
      plan_noise();
    end
  endfunction

  function automatic void plan_directed();
    plan_lookup(8'd0, 8'd0);
    plan_noise();
    // gap run then one long run up to the top symbol
    plan_run(8'd255, 5'd0, 8'd0, 8'd0);
    plan_run(8'd255, 5'd1, 8'd254, 8'd255);
    plan_count(8'd255, 6'd2);
    plan_lookup(8'd255, 8'd0);
    plan_lookup(8'd255, 8'd1);
    plan_lookup(8'd255, 8'd255);
    // count above the limit saturates
    plan_run(8'd1, 5'd0, 8'd255, 8'haa);
    plan_count(8'd1, 6'd63);
    plan_lookup(8'd1, 8'd255);
    // run boundaries and runs ending before the symbol
    plan_run(8'd2, 5'd0, 8'd9, 8'd5);
    plan_run(8'd2, 5'd1, 8'd9, 8'd6);
    plan_count(8'd2, 6'd2);
    plan_lookup(8'd2, 8'd9);
    plan_lookup(8'd2, 8'd10);
    plan_lookup(8'd2, 8'd19);
    plan_lookup(8'd2, 8'd20);
    plan_count(8'd2, 6'd0);
    plan_lookup(8'd2, 8'd0);
    plan_run(8'd3, 5'd31, 8'd255, 8'h55);
    plan_count(8'd3, 6'd32);
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_moves.size() != 0);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
      foreach (runs_in_state[s]) runs_in_state[s] = '0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_request(in_data);
        if (in_data.opcode != OP_UNUSED) accepted_requests++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_data <= pending_requests.pop_front();
          in_valid <= 1'b1;
          send_wait = pick_idle(gap_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_move(out_data);
        // long hold-off so the block backs up into the request side
        if (lookups_checked == 60) recv_wait = 400;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        recv_wait = pick_idle(stall_on);
        out_ready <= (recv_wait == 0);
      end
    end
  end

  initial begin
    int phase_end;
    foreach (plan_runs[s]) begin
      plan_runs[s] = 0;
      plan_written[s] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    plan_directed();
    wait_drained();
    for (int phase = 0; phase < 6; phase++) begin
      gap_on = (phase % 4 == 0) || (phase % 4 == 2);
      stall_on = (phase % 4 == 0) || (phase % 4 == 3);
      phase_end = planned_items + PHASE_ITEMS;
      while (planned_items < phase_end) plan_random_step();
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d requests: %0d run writes, %0d count writes (%0d saturating)",
             accepted_requests, run_writes, count_writes, saturating_counts);
    $display("checked %0d lookups: %0d hits, %0d gap-run hits, %0d misses",
             lookups_checked, hits, gap_hits, misses);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
src/rdtl_pkg.sv
src/rdtl_run_mem.sv
src/rdtl_count_mem.sv
src/rle_dfa_transition_lookup_unit.sv
tb/rle_dfa_transition_lookup_unit_test.sv
